FILE: design/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg: shared definitions for the accelerometer step detector
// Action codes, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int AXIS_BITS_DEFAULT      = 12;
    localparam int ADAPT_INTERVAL_DEFAULT = 4;

    localparam int MAG_W  = 24;
    localparam int GAP_W  = 16;
    localparam int IDLE_W = 16;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 8;

    localparam logic [MAG_W-1:0]  MAG_MAX      = '1;
    localparam logic [MAG_W-1:0]  MAG_RESET    = MAG_W'(100000);
    localparam logic [MAG_W-1:0]  DIFF_DEFAULT = MAG_W'(10);
    localparam logic [GAP_W-1:0]  GAP_DEFAULT  = GAP_W'(250);
    localparam logic [IDLE_W-1:0] IDLE_DEFAULT = IDLE_W'(300);
    localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

    typedef enum logic [1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_REPORT  = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_MIN_DIFF = 2'd0,
        REG_MIN_GAP  = 2'd1,
        REG_IDLE     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic             report_valid;
        logic [CNT_W-1:0] reported_steps;
        logic             activity;
        logic             activity_changed;
    } result_t;

endpackage

FILE: design/accel_step_detector.sv
// ----------------------------------------------------------------------------
// accel_step_detector: pedometer counting peaks of the squared acceleration
// Input register with magnitude, one pass of step logic, output register.
// ----------------------------------------------------------------------------
// One transaction enters per clock unless the block stalls, and yields exactly one
// result transaction. The squared magnitude of the three axes is formed on the
// way into the input register, and the step/activity logic runs between the
// input register and the output register, which drives m_tvalid. Throughput is
// one item per cycle, set by the single update of the detector state in that
// second stage; the block stalls only when both the input and the output
// register hold a transaction and the sink holds m_tready low. s_tuser carries
// the action
// (0 sample, 1 report tick, 2 restart, 3 ignored). Configuration registers at
// byte addresses 0 (smallest magnitude change kept, 0 acts as 10), 4 (min_step_gap_ms) and
// 8 (idle_time_ms) must be written only while the block is idle.
module accel_step_detector #(
    parameter int AXIS_BITS      = asd_pkg::AXIS_BITS_DEFAULT,
    parameter int ADAPT_INTERVAL = asd_pkg::ADAPT_INTERVAL_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: accel_x, accel_y, accel_z, time_ms, zero fill
    input  logic [((3*AXIS_BITS+32+7)/8)*8-1:0] s_tdata,
    // fields from bit 0: action
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // fields from bit 0: reported_steps, activity, activity_changed, zero fill
    output logic [15:0] m_tdata,
    // fields from bit 0: report_valid
    output logic        m_tuser,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import asd_pkg::*;

    localparam int SUM_W   = 2*AXIS_BITS + 2;
    localparam int EXT_W   = (SUM_W > MAG_W) ? SUM_W : MAG_W;
    localparam int PHASE_W = (ADAPT_INTERVAL > 1) ? $clog2(ADAPT_INTERVAL) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(ADAPT_INTERVAL - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]  min_diff_reg;
    logic [GAP_W-1:0]  min_gap_reg;
    logic [IDLE_W-1:0] idle_reg;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_diff_reg <= DIFF_DEFAULT;
            min_gap_reg  <= GAP_DEFAULT;
            idle_reg     <= IDLE_DEFAULT;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_MIN_DIFF: min_diff_reg <= pwdata[MAG_W-1:0];
                REG_MIN_GAP:  min_gap_reg  <= pwdata[GAP_W-1:0];
                REG_IDLE:     idle_reg     <= pwdata[IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the raw register value
    always_comb begin
        case (cfg_idx)
            REG_MIN_DIFF: prdata = 32'(min_diff_reg);
            REG_MIN_GAP:  prdata = 32'(min_gap_reg);
            REG_IDLE:     prdata = 32'(idle_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the output register in any output-free cycle
    // ------------------------------------------------------------------
    logic    in_valid_reg;
    logic    m_tvalid_reg;
    result_t result_reg;
    logic    out_free;
    logic    fire;
    logic    s_accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Squared magnitude, formed on capture
    // ------------------------------------------------------------------
    logic signed [AXIS_BITS-1:0]   ax, ay, az;
    logic signed [2*AXIS_BITS-1:0] sq_x, sq_y, sq_z;
    logic [SUM_W-1:0]              mag_sum;
    logic [EXT_W-1:0]              mag_ext;
    logic [MAG_W-1:0]              mag_in;

    assign ax   = $signed(s_tdata[AXIS_BITS-1:0]);
    assign ay   = $signed(s_tdata[2*AXIS_BITS-1:AXIS_BITS]);
    assign az   = $signed(s_tdata[3*AXIS_BITS-1:2*AXIS_BITS]);
    assign sq_x = ax * ax;
    assign sq_y = ay * ay;
    assign sq_z = az * az;
    assign mag_sum = SUM_W'($unsigned(sq_x)) + SUM_W'($unsigned(sq_y))
                   + SUM_W'($unsigned(sq_z));
    assign mag_ext = EXT_W'(mag_sum);
    // Saturate at the top of the 24-bit range
    assign mag_in  = (mag_ext > EXT_W'(MAG_MAX)) ? MAG_MAX : mag_ext[MAG_W-1:0];

    action_t           action_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [TIME_W-1:0] time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        // Payload: load on every accepted transaction, no reset
        if (s_accept) begin
            action_reg <= action_t'(s_tuser);
            mag_reg    <= mag_in;
            time_reg   <= s_tdata[3*AXIS_BITS+TIME_W-1:3*AXIS_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]   prev_mag_reg,  prev_mag_next;
    logic               rising_reg,    rising_next;
    logic [TIME_W-1:0]  last_step_reg, last_step_next;
    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic [CNT_W-1:0]   pending_reg,   pending_next;
    logic               walking_reg,   walking_next;
    result_t            result_next;

    // Sample path terms
    logic [TIME_W-1:0] last_step_adj;
    logic [TIME_W-1:0] elapsed;
    logic              phase_wrap;
    logic              walk_adapt;
    logic              now_rising;
    logic [MAG_W-1:0]  diff_size;
    logic              keep;
    logic [MAG_W-1:0]  thr;
    logic              step;

    // Pull the step time back if the clock went backwards
    assign last_step_adj = (time_reg < last_step_reg) ? time_reg : last_step_reg;
    assign elapsed       = time_reg - last_step_adj;
    assign phase_wrap    = (phase_reg == PHASE_LAST);
    assign walk_adapt    = phase_wrap ? (elapsed < TIME_W'(idle_reg)) : walking_reg;
    assign now_rising    = (mag_reg > prev_mag_reg);
    assign diff_size     = now_rising ? (mag_reg - prev_mag_reg) : (prev_mag_reg - mag_reg);
    assign thr           = (min_diff_reg == '0) ? DIFF_DEFAULT : min_diff_reg;
    assign keep          = (diff_size >= thr);
    // Peak: rising turns to falling with enough gap since the last step
    assign step = keep && rising_reg && !now_rising && (elapsed > TIME_W'(min_gap_reg));

    always_comb begin
        prev_mag_next  = prev_mag_reg;
        rising_next    = rising_reg;
        last_step_next = last_step_reg;
        phase_next     = phase_reg;
        pending_next   = pending_reg;
        walking_next   = walking_reg;
        result_next    = '0;

        case (action_reg)
            ACT_SAMPLE: begin
                phase_next     = phase_wrap ? '0 : phase_reg + 1'b1;
                walking_next   = step ? 1'b1 : walk_adapt;
                last_step_next = step ? time_reg : last_step_adj;
                if (step && pending_reg != CNT_MAX) begin
                    pending_next = pending_reg + 1'b1;
                end
                if (keep) begin
                    rising_next   = now_rising;
                    prev_mag_next = mag_reg;
                end
            end
            ACT_REPORT: begin
                if (pending_reg != '0) begin
                    result_next.report_valid   = 1'b1;
                    result_next.reported_steps = pending_reg;
                    pending_next               = '0;
                end
            end
            ACT_RESTART: begin
                prev_mag_next  = MAG_RESET;
                rising_next    = 1'b0;
                last_step_next = '0;
                phase_next     = '0;
                pending_next   = '0;
                walking_next   = 1'b0;
            end
            default: ;
        endcase

        result_next.activity         = walking_next;
        result_next.activity_changed = walking_next ^ walking_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mag_reg  <= MAG_RESET;
            rising_reg    <= 1'b0;
            last_step_reg <= '0;
            phase_reg     <= '0;
            pending_reg   <= '0;
            walking_reg   <= 1'b0;
        end else if (fire) begin
            prev_mag_reg  <= prev_mag_next;
            rising_reg    <= rising_next;
            last_step_reg <= last_step_next;
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
            walking_reg   <= walking_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold until the sink takes the transaction
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= in_valid_reg;
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.report_valid;
    assign m_tdata  = {6'd0, result_reg.activity_changed, result_reg.activity,
                       result_reg.reported_steps};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A report flag always comes with a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[CNT_W-1:0] != '0))
        else $error("report flagged with zero step count");

    // A restart leaves the detector idle with no pending steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && action_reg == ACT_RESTART) |=>
            (pending_reg == '0 && !walking_reg && prev_mag_reg == MAG_RESET))
        else $error("restart did not clear detector state");

    // A handed-out report clears the pending count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && action_reg == ACT_REPORT) |=> (pending_reg == '0))
        else $error("report did not clear pending steps");

    // An empty output register never stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled while output register empty");

endmodule

FILE: dv/accel_step_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_step_detector_tb: self-checking bench for the step detector
// Streams samples, report ticks and restarts into the block, mirrors the
// pedometer state to predict every result, and checks results in order while
// both stream sides idle and stall at random and the registers are reprogrammed.
// ----------------------------------------------------------------------------
module accel_step_detector_tb;
    import asd_pkg::*;

    localparam int AXIS_W         = AXIS_BITS_DEFAULT;
    localparam int SDATA_W        = ((3*AXIS_W+32+7)/8)*8;
    localparam int ADAPT_EVERY    = ADAPT_INTERVAL_DEFAULT;
    localparam int MAG_CEIL       = 16777215;
    localparam int MAG_START      = 100000;
    localparam int DIFF_FALLBACK  = 10;
    localparam int RESET_MIN_GAP  = 250;
    localparam int RESET_IDLE     = 300;
    localparam int COUNT_CEIL     = 255;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SHOWN      = 10;
    // action code 3 is not decoded by the block
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

    typedef struct {
        logic [1:0]               act;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        logic [31:0]              stamp;
    } motion_item_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SDATA_W-1:0] s_tdata  = '0;
    logic [1:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;
    logic               m_tuser;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [3:0]         paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    always #5 aclk = ~aclk;

    accel_step_detector i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    motion_item_t samples_to_send[$];   // items waiting for the driver
    result_t      reports_due[$];       // predicted results, oldest first

    // register copies, updated when the APB write lands
    logic [23:0] cfg_min_diff = 24'(DIFF_FALLBACK);
    logic [15:0] cfg_min_gap  = 16'(RESET_MIN_GAP);
    logic [15:0] cfg_idle     = 16'(RESET_IDLE);

    // mirrored detector state
    logic [23:0] prev_mag;
    logic        was_rising;
    logic [31:0] step_time;
    int          adapt_phase;
    logic [7:0]  step_count;
    logic        walking_now;

    // stimulus shaping, set per phase by the sequence
    int          sender_gap_max = 0;
    bit          send_hold      = 1'b0;
    ready_mode_t ready_mode     = READY_ALWAYS;
    logic [7:0]  ready_rot      = 8'b1011_0110;
    logic [31:0] walk_clock     = 32'd5000;

    // statistics and errors
    int items_accepted = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int steps_total    = 0;
    bit full_count_seen = 1'b0;
    int idle_cycles    = 0;

    // ------------------------------------------------------------------------
    // Pedometer predictor
    // ------------------------------------------------------------------------
    function automatic void clear_detector_state();
        prev_mag    = 24'(MAG_START);
        was_rising  = 1'b0;
        step_time   = '0;
        adapt_phase = 0;
        step_count  = '0;
        walking_now = 1'b0;
    endfunction

    function automatic result_t predict_pedometer(motion_item_t it);
        result_t     res;
        logic        was_walking;
        int          ix;
        int          iy;
        int          iz;
        int          sq_sum;
        logic [23:0] mag;
        int          delta;
        int          delta_abs;
        int          thr;
        logic [31:0] elapsed;
        logic        now_rising;
        res         = '0;
        was_walking = walking_now;
        case (it.act)
            ACT_SAMPLE: begin
                ix     = it.ax;
                iy     = it.ay;
                iz     = it.az;
                sq_sum = ix*ix + iy*iy + iz*iz;
                mag    = (sq_sum > MAG_CEIL) ? 24'(MAG_CEIL) : 24'(sq_sum);
                delta  = int'(mag) - int'(prev_mag);
                delta_abs = (delta < 0) ? -delta : delta;
                thr    = (cfg_min_diff == 0) ? DIFF_FALLBACK : int'(cfg_min_diff);
                // pull the step time back when the timestamp went backwards
                if (it.stamp < step_time) begin
                    step_time = it.stamp;
                end
                adapt_phase = (adapt_phase + 1) % ADAPT_EVERY;
                elapsed = it.stamp - step_time;
                if (adapt_phase == 0) begin
                    walking_now = (elapsed < {16'd0, cfg_idle});
                end
                if (delta_abs >= thr) begin
                    now_rising = (delta > 0);
                    if (was_rising && !now_rising && elapsed > {16'd0, cfg_min_gap}) begin
                        if (step_count != 8'(COUNT_CEIL)) begin
                            step_count = step_count + 8'd1;
                        end
                        step_time   = it.stamp;
                        walking_now = 1'b1;
                    end
                    was_rising = now_rising;
                    prev_mag   = mag;
                end
            end
            ACT_REPORT: begin
                if (step_count != 0) begin
                    res.report_valid   = 1'b1;
                    res.reported_steps = step_count;
                    step_count         = '0;
                end
            end
            ACT_RESTART: begin
                clear_detector_state();
            end
            default: ;
        endcase
        res.activity         = walking_now;
        res.activity_changed = (walking_now != was_walking);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic motion_item_t make_item(logic [1:0] act, int x, int y, int z,
                                               logic [31:0] stamp);
        motion_item_t it;
        it.act   = act;
        it.ax    = AXIS_W'(x);
        it.ay    = AXIS_W'(y);
        it.az    = AXIS_W'(z);
        it.stamp = stamp;
        return it;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // High swing: one axis near full scale; low swing: all axes small.
    // The two magnitude bands never overlap, so each swap is a clear turn.
    function automatic motion_item_t swing_sample(bit high, logic [31:0] stamp);
        int big;
        big = rand_between(1200, 2047);
        if ($urandom_range(1)) begin
            big = -big;
        end
        if (high) begin
            return make_item(ACT_SAMPLE, rand_between(-600, 600), rand_between(-600, 600),
                             big, stamp);
        end
        return make_item(ACT_SAMPLE, rand_between(-300, 300), rand_between(-300, 300),
                         rand_between(-300, 300), stamp);
    endfunction

    // Walking pattern with random stride timing, mixed with ticks, restarts and noise.
    task automatic queue_walk(int count, int noise_pct);
        int k;
        int r;
        bit up;
        int run_left;
        up       = 1'b1;
        run_left = 1;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < noise_pct) begin
                // fully random item: any action, any timestamp
                samples_to_send.push_back(make_item(2'($urandom_range(3)),
                    rand_between(-2048, 2047), rand_between(-2048, 2047),
                    rand_between(-2048, 2047), $urandom()));
            end else if (r < noise_pct + 4) begin
                samples_to_send.push_back(make_item(ACT_REPORT, 0, 0, 0, '0));
            end else if (r < noise_pct + 5) begin
                samples_to_send.push_back(make_item(ACT_RESTART, 0, 0, 0, '0));
            end else begin
                walk_clock += $urandom_range(10, 150);
                samples_to_send.push_back(swing_sample(up, walk_clock));
                run_left--;
                if (run_left == 0) begin
                    up       = !up;
                    run_left = $urandom_range(1, 3);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration port: setup cycle, access cycle, write at the access edge
    // ------------------------------------------------------------------------
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_DIFF: cfg_min_diff = value[23:0];
            REG_MIN_GAP:  cfg_min_gap  = value[15:0];
            REG_IDLE:     cfg_idle     = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] min_diff, logic [31:0] min_gap,
                             logic [31:0] idle);
        write_register(REG_MIN_DIFF, min_diff);
        write_register(REG_MIN_GAP, min_gap);
        write_register(REG_IDLE, idle);
    endtask

    // Hold until every queued item went in and every result came back,
    // then let the pipeline settle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (samples_to_send.size() != 0 || s_tvalid || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued items in bursts, predict on acceptance
    // ------------------------------------------------------------------------
    motion_item_t item_on_bus;
    int           burst_left = 0;
    int           gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                reports_due.push_back(predict_pedometer(item_on_bus));
                items_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the transaction until the block takes it
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (!send_hold && samples_to_send.size() != 0) begin
                item_on_bus = samples_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(SDATA_W-3*AXIS_W-32){1'b0}}, item_on_bus.stamp,
                             item_on_bus.az, item_on_bus.ay, item_on_bus.ax};
                s_tuser  <= item_on_bus.act;
                // end of burst: pick the next burst length and the gap after it
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, sender_gap_max);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction, then pick
    // the next ready value from the current stall pattern
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("error: result with no prediction waiting, data=%h user=%b",
                             m_tdata, m_tuser);
                end
            end else begin
                want = reports_due.pop_front();
                if (m_tuser !== want.report_valid || m_tdata[7:0] !== want.reported_steps
                        || m_tdata[8] !== want.activity
                        || m_tdata[9] !== want.activity_changed
                        || m_tdata[15:10] !== 6'd0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display({"error: result %0d want valid=%0d steps=%0d act=%0d chg=%0d,",
                                  " got valid=%0d steps=%0d act=%0d chg=%0d fill=%h"},
                                 results_seen, want.report_valid, want.reported_steps,
                                 want.activity, want.activity_changed, m_tuser,
                                 m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[15:10]);
                    end
                end
                if (m_tuser === 1'b1) begin
                    steps_total += m_tdata[7:0];
                    if (m_tdata[7:0] == 8'(COUNT_CEIL)) begin
                        full_count_seen = 1'b1;
                    end
                end
            end
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_RANDOM: m_tready <= ($urandom_range(99) < 70);
            default: begin
                ready_rot = {ready_rot[0], ready_rot[7:1]};
                m_tready <= ready_rot[0];
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("error: no transaction for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, reports_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int k;
        int hold_at;
        clear_detector_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part on reset register values, no idling on either side.
        // Report with nothing counted, then the unused action code.
        samples_to_send.push_back(make_item(ACT_REPORT, 0, 0, 0, '0));
        samples_to_send.push_back(make_item(ACT_UNUSED, 0, 0, 0, '0));
        // Full-scale axes: rise to the largest magnitude, fall to the next
        // largest one and count a step, then quiet samples.
        samples_to_send.push_back(make_item(ACT_SAMPLE, -2048, -2048, -2048, 32'd1000));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 2047, 2047, 2047, 32'd1300));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd1310));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd1320));
        samples_to_send.push_back(make_item(ACT_REPORT, 0, 0, 0, '0));
        // Timestamp goes backwards; change one below the threshold, then
        // exactly at it, then a fall too soon after the last step.
        samples_to_send.push_back(make_item(ACT_SAMPLE, 3, 0, 0, 32'd500));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 3, 1, 0, 32'd510));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd520));
        // Long quiet stretch: adapt drops to idle.
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2000));
        // Step, then adapt to idle and a step in the same sample (no net change).
        samples_to_send.push_back(make_item(ACT_SAMPLE, 100, 0, 0, 32'd2010));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2300));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 100, 0, 0, 32'd2310));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2700));
        // Fall exactly at the minimum gap (no step), then just past it.
        samples_to_send.push_back(make_item(ACT_SAMPLE, 100, 0, 0, 32'd2710));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2950));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 100, 0, 0, 32'd2960));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2961));
        // Quiet samples up to the next adapt, which lands exactly at the
        // idle time and goes idle.
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2970));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2980));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd2990));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd3261));
        // Step back to walking, report, restart while walking.
        samples_to_send.push_back(make_item(ACT_SAMPLE, 100, 0, 0, 32'd3270));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd3600));
        samples_to_send.push_back(make_item(ACT_REPORT, 0, 0, 0, '0));
        samples_to_send.push_back(make_item(ACT_RESTART, 0, 0, 0, '0));
        // Timestamp extremes after the restart.
        samples_to_send.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 32'd0));
        samples_to_send.push_back(make_item(ACT_SAMPLE, 1, 0, -1, 32'hFFFF_FFFF));
        wait_drained();

        // Threshold written as 0 falls back to the default.
        configure(32'd0, 32'(RESET_MIN_GAP), 32'(RESET_IDLE));
        sender_gap_max = 6;
        ready_mode     = READY_RANDOM;
        walk_clock     = 32'd10000;
        queue_walk(40, 8);
        wait_drained();

        // Largest settings: no change ever reaches the threshold.
        configure(32'h00FF_FFFF, 32'hFFFF, 32'hFFFF);
        sender_gap_max = 3;
        ready_mode     = READY_PATTERN;
        queue_walk(30, 30);
        wait_drained();

        // Smallest settings: every turn counts, push the counter past full.
        configure(32'd1, 32'd0, 32'd0);
        sender_gap_max = 2;
        ready_mode     = READY_RANDOM;
        samples_to_send.push_back(make_item(ACT_RESTART, 0, 0, 0, '0));
        walk_clock = 32'd100;
        for (k = 0; k < 520; k++) begin
            walk_clock += $urandom_range(1, 40);
            samples_to_send.push_back(swing_sample(k[0] == 1'b0, walk_clock));
        end
        samples_to_send.push_back(make_item(ACT_REPORT, 0, 0, 0, '0));
        wait_drained();

        // Random mid-range settings, with a full drain in the middle.
        configure($urandom_range(1, 4000), $urandom_range(0, 400), $urandom_range(0, 800));
        sender_gap_max = 8;
        ready_mode     = READY_PATTERN;
        hold_at        = items_accepted + 25;
        queue_walk(40, 8);
        do @(negedge aclk); while (items_accepted < hold_at);
        send_hold = 1'b1;
        do @(negedge aclk); while (s_tvalid || reports_due.size() != 0);
        repeat (5) @(posedge aclk);
        send_hold = 1'b0;
        wait_drained();

        if (reports_due.size() != 0) begin
            mismatches += reports_due.size();
            $display("error: %0d predicted results never arrived", reports_due.size());
        end
        $display("covered %0d transactions in and %0d results out, %0d mismatches",
                 items_accepted, results_seen, mismatches);
        $display("reported %0d steps in total, full step counter %s",
                 steps_total, full_count_seen ? "reached" : "not reached");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
design/asd_pkg.sv
design/accel_step_detector.sv
dv/accel_step_detector_tb.sv
